/* design/exprtok_pkg.sv */
// Shared types, codes and character-class functions for the expression tokenizer.
// No dependencies; used by exprtok_lex, exprtok_outq and expression_tokenizer_top.
package exprtok_pkg;

    localparam int unsigned EXPRTOK_MAX_LEN = 255;

    typedef enum logic [2:0] {
        S_IDLE      = 3'd0,
        S_IDENT     = 3'd1,
        S_INT       = 3'd2,
        S_FRAC      = 3'd3,
        S_LEAD_DOT  = 3'd4,
        S_EXP_START = 3'd5,
        S_EXP_SIGN  = 3'd6,
        S_EXP_DIG   = 3'd7
    } t_scan;

    // Keyword prefix tracker: every code but KW_NONE names a prefix of sin, cos, sqrt, int, L or BA
    typedef enum logic [3:0] {
        KW_NONE = 4'd0,
        KW_S    = 4'd1,
        KW_SI   = 4'd2,
        KW_SIN  = 4'd3,
        KW_C    = 4'd4,
        KW_CO   = 4'd5,
        KW_COS  = 4'd6,
        KW_SQ   = 4'd7,
        KW_SQR  = 4'd8,
        KW_SQRT = 4'd9,
        KW_I    = 4'd10,
        KW_IN   = 4'd11,
        KW_INT  = 4'd12,
        KW_L    = 4'd13,
        KW_B    = 4'd14,
        KW_BA   = 4'd15
    } t_kw;

    typedef enum logic [3:0] {
        K_EOF    = 4'd0,
        K_NUMBER = 4'd1,
        K_IDENT  = 4'd2,
        K_SIN    = 4'd3,
        K_COS    = 4'd4,
        K_SQRT   = 4'd5,
        K_INT    = 4'd6,
        K_L      = 4'd7,
        K_BA     = 4'd8,
        K_PUNCT  = 4'd9,
        K_ERROR  = 4'd10
    } t_kind;

    typedef struct packed {
        logic [7:0] ch;
        logic       eos;
    } t_in;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] punct;
        logic [7:0] len;
        logic       last;
    } t_tok;

    // Results of one step of the scanner
    typedef struct packed {
        logic [1:0] num;
        t_tok       tok0;
        t_tok       tok1;
    } t_lex_out;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return (c == "=") || (c == "+") || (c == "-") || (c == "*") || (c == "/") ||
               (c == "%") || (c == "^") || (c == "(") || (c == ")") || (c == ",");
    endfunction

    function automatic t_kw kw_first(input logic [7:0] c);
        t_kw k;
        k = KW_NONE;
        if (c == "s") k = KW_S;
        else if (c == "c") k = KW_C;
        else if (c == "i") k = KW_I;
        else if (c == "L") k = KW_L;
        else if (c == "B") k = KW_B;
        return k;
    endfunction

    function automatic t_kw kw_next(input t_kw m, input logic [7:0] c);
        t_kw k;
        k = KW_NONE;
        unique case (m)
            KW_S:    k = (c == "i") ? KW_SI : ((c == "q") ? KW_SQ : KW_NONE);
            KW_SI:   k = (c == "n") ? KW_SIN : KW_NONE;
            KW_C:    k = (c == "o") ? KW_CO : KW_NONE;
            KW_CO:   k = (c == "s") ? KW_COS : KW_NONE;
            KW_SQ:   k = (c == "r") ? KW_SQR : KW_NONE;
            KW_SQR:  k = (c == "t") ? KW_SQRT : KW_NONE;
            KW_I:    k = (c == "n") ? KW_IN : KW_NONE;
            KW_IN:   k = (c == "t") ? KW_INT : KW_NONE;
            KW_B:    k = (c == "A") ? KW_BA : KW_NONE;
            default: k = KW_NONE;
        endcase
        return k;
    endfunction

    function automatic t_kind ident_kind(input t_kw m);
        t_kind k;
        unique case (m)
            KW_SIN:  k = K_SIN;
            KW_COS:  k = K_COS;
            KW_SQRT: k = K_SQRT;
            KW_INT:  k = K_INT;
            KW_L:    k = K_L;
            KW_BA:   k = K_BA;
            default: k = K_IDENT;
        endcase
        return k;
    endfunction

endpackage

/* design/exprtok_lex.sv */
// Scanner state and per-character token logic of the expression tokenizer.
// Depends on exprtok_pkg.
module exprtok_lex
    import exprtok_pkg::*;
#(
    parameter int unsigned MAX_TOKEN_LEN = EXPRTOK_MAX_LEN
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_step,     // commit the item in i_in
    input  t_in      i_in,
    output t_lex_out o_res
);

    localparam int unsigned LEN_CAP_I = (MAX_TOKEN_LEN > 255) ? 255 : MAX_TOKEN_LEN;
    localparam logic [7:0]  LEN_CAP   = LEN_CAP_I[7:0];

    t_scan      r_scan, n_scan;
    t_kw        r_kw, n_kw;
    logic [7:0] r_len, n_len;
    logic       r_halt, n_halt;

    logic [7:0] len_inc;
    logic [7:0] c;

    // Scan of c from the idle state
    t_scan      id_scan;
    t_kw        id_kw;
    logic [7:0] id_len;
    logic       id_emit;
    logic       id_halt;
    t_tok       id_tok;

    assign c       = i_in.ch;
    assign len_inc = (r_len < LEN_CAP) ? (r_len + 8'd1) : r_len;

    always_comb begin
        id_scan = S_IDLE;
        id_kw   = KW_NONE;
        id_len  = 8'd0;
        id_emit = 1'b0;
        id_halt = 1'b0;
        id_tok  = '{kind: K_PUNCT, punct: c, len: 8'd1, last: 1'b0};
        priority if (is_space(c)) begin
            id_scan = S_IDLE;
        end else if (is_letter(c)) begin
            id_scan = S_IDENT;
            id_kw   = kw_first(c);
            id_len  = 8'd1;
        end else if (is_digit(c)) begin
            id_scan = S_INT;
            id_len  = 8'd1;
        end else if (c == ".") begin
            id_scan = S_LEAD_DOT;
            id_len  = 8'd1;
        end else if (is_punct(c)) begin
            id_emit = 1'b1;
        end else begin
            id_emit     = 1'b1;
            id_halt     = 1'b1;
            id_tok.kind = K_ERROR;
        end
    end

    always_comb begin
        logic term;
        logic err;
        t_tok pend;

        term   = 1'b0;
        err    = 1'b0;
        pend   = '{kind: K_NUMBER, punct: 8'd0, len: r_len, last: 1'b0};
        n_scan = r_scan;
        n_kw   = r_kw;
        n_len  = r_len;
        n_halt = r_halt;
        o_res  = '0;

        if (i_in.eos) begin
            // Flush the pending token, then end-of-file; return to the reset state
            o_res.tok0 = '{kind: K_EOF, punct: 8'd0, len: 8'd0, last: 1'b1};
            o_res.num  = 2'd1;
            if (!r_halt && (r_scan != S_IDLE)) begin
                unique case (r_scan)
                    S_IDENT:                        pend.kind = ident_kind(r_kw);
                    S_INT, S_FRAC, S_EXP_DIG:       pend.kind = K_NUMBER;
                    S_LEAD_DOT, S_EXP_START,
                    S_EXP_SIGN:                     pend.kind = K_ERROR;
                    default:                        pend.kind = K_NUMBER;
                endcase
                o_res.tok1 = o_res.tok0;
                o_res.tok0 = pend;
                o_res.num  = 2'd2;
            end
            n_scan = S_IDLE;
            n_kw   = KW_NONE;
            n_len  = 8'd0;
            n_halt = 1'b0;
        end else if (!r_halt) begin
            unique case (r_scan)
                S_IDLE: begin
                    n_scan     = id_scan;
                    n_kw       = id_kw;
                    n_len      = id_len;
                    n_halt     = id_halt;
                    o_res.num  = {1'b0, id_emit};
                    o_res.tok0 = id_tok;
                    o_res.tok0.last = 1'b1;
                end
                S_IDENT: begin
                    if (is_letter(c)) begin
                        n_kw  = kw_next(r_kw, c);
                        n_len = len_inc;
                    end else begin
                        pend.kind = ident_kind(r_kw);
                        term      = 1'b1;
                    end
                end
                S_INT, S_FRAC: begin
                    priority if (is_digit(c)) begin
                        n_len = len_inc;
                    end else if ((c == ".") && (r_scan == S_INT)) begin
                        n_scan = S_FRAC;
                        n_len  = len_inc;
                    end else if ((c == "e") || (c == "E")) begin
                        n_scan = S_EXP_START;
                        n_len  = len_inc;
                    end else begin
                        term = 1'b1;
                    end
                end
                S_LEAD_DOT: begin
                    if (is_digit(c)) begin
                        n_scan = S_FRAC;
                        n_len  = len_inc;
                    end else begin
                        err = 1'b1;
                    end
                end
                S_EXP_START: begin
                    priority if ((c == "+") || (c == "-")) begin
                        n_scan = S_EXP_SIGN;
                        n_len  = len_inc;
                    end else if (is_digit(c)) begin
                        n_scan = S_EXP_DIG;
                        n_len  = len_inc;
                    end else begin
                        err = 1'b1;
                    end
                end
                S_EXP_SIGN: begin
                    if (is_digit(c)) begin
                        n_scan = S_EXP_DIG;
                        n_len  = len_inc;
                    end else begin
                        err = 1'b1;
                    end
                end
                S_EXP_DIG: begin
                    if (is_digit(c)) begin
                        n_len = len_inc;
                    end else begin
                        term = 1'b1;
                    end
                end
                default: begin
                    n_scan = S_IDLE;
                end
            endcase

            if (err) begin
                // Malformed number: the offending byte counts towards the length
                o_res.num  = 2'd1;
                o_res.tok0 = '{kind: K_ERROR, punct: c, len: len_inc, last: 1'b1};
                n_scan     = S_IDLE;
                n_kw       = KW_NONE;
                n_len      = 8'd0;
                n_halt     = 1'b1;
            end else if (term) begin
                // Close the token, then rescan the same byte from idle
                o_res.tok0 = pend;
                n_scan     = id_scan;
                n_kw       = id_kw;
                n_len      = id_len;
                n_halt     = id_halt;
                if (id_emit) begin
                    o_res.num       = 2'd2;
                    o_res.tok1      = id_tok;
                    o_res.tok1.last = 1'b1;
                end else begin
                    o_res.num       = 2'd1;
                    o_res.tok0.last = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= S_IDLE;
            r_kw   <= KW_NONE;
            r_len  <= 8'd0;
            r_halt <= 1'b0;
        end else if (i_step) begin
            r_scan <= n_scan;
            r_kw   <= n_kw;
            r_len  <= n_len;
            r_halt <= n_halt;
        end
    end

`ifndef ASSERT_OFF
    a_eos_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_in.eos) |=> (r_scan == S_IDLE) && !r_halt && (r_len == 8'd0))
        else $error("end of stream did not return the scanner to idle");
    a_halt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |-> (r_scan == S_IDLE))
        else $error("halted while inside a token");
    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_CAP)
        else $error("token length beyond its cap");
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_scan == S_IDLE) |-> ((r_len == 8'd0) && (r_kw == KW_NONE)))
        else $error("idle scanner holds a stale length or keyword prefix");
`endif

endmodule

/* design/exprtok_outq.sv */
// Two-entry result queue of the expression tokenizer; takes up to two tokens a cycle, as many as it has free entries.
// Depends on exprtok_pkg.
module exprtok_outq
    import exprtok_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_push_num,   // never more than o_free
    input  t_tok       i_tok0,
    input  t_tok       i_tok1,
    output logic [1:0] o_free,
    output logic       o_valid,
    input  logic       i_ready,
    output t_tok       o_tok
);

    logic [1:0] r_count, n_count;
    t_tok       r_q0, n_q0;
    t_tok       r_q1, n_q1;
    logic       pop;
    logic [1:0] base;

    assign o_valid = (r_count != 2'd0);
    assign o_tok   = r_q0;
    assign o_free  = 2'd2 - r_count;
    assign pop     = o_valid && i_ready;
    assign base    = r_count - {1'b0, pop};

    always_comb begin
        n_q0 = pop ? r_q1 : r_q0;
        n_q1 = r_q1;
        if (i_push_num != 2'd0) begin
            if (base == 2'd0) begin
                n_q0 = i_tok0;
            end else begin
                n_q1 = i_tok0;
            end
        end
        if (i_push_num == 2'd2) begin
            n_q1 = i_tok1;
        end
        n_count = base + i_push_num;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, base} + {1'b0, i_push_num}) <= 3'd2)
        else $error("result queue overflow");
`endif

endmodule

/* design/expression_tokenizer_top.sv */
// Expression tokenizer: one character per input beat, tokens out.
// Input beats go through a holding register into the scanner (exprtok_lex); tokens are
// queued in exprtok_outq. Depends on exprtok_pkg.
//
// Usage:
//   Input stream: i_s_axis_tdata carries one ASCII character; i_s_axis_tlast marks end
//   of stream (the character is then ignored). Output stream: one token per beat, kind in
//   o_m_axis_tuser, punctuation/error byte and length in o_m_axis_tdata, o_m_axis_tlast on
//   the final token caused by an input character.
//   A character that closes a token is first accepted into the input holding register; the
//   token is then written into the result queue and offered at the output from there.
//   Throughput: one character per cycle while the result queue has room for its tokens. A
//   character that yields two tokens (a closed token plus a punctuation or error token, or a
//   pending token plus end-of-file) is taken only when the result queue is empty.
//   The input holding register and the two-entry result queue decouple the sides: input is
//   still taken while a token waits to be read. When the receiver stalls, the queue fills
//   and o_s_axis_tready falls once the holding register is occupied.
//   Reset (synchronous, active low) empties both buffers and returns the scanner to idle.
module expression_tokenizer_top
    import exprtok_pkg::*;
#(
    parameter int unsigned MAX_TOKEN_LEN = EXPRTOK_MAX_LEN
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] ch
    input  logic        i_s_axis_tlast,   // end_of_stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [7:0] punct_char, [15:8] token_length
    output logic [3:0]  o_m_axis_tuser,   // [3:0] token_kind
    output logic        o_m_axis_tlast    // last
);

    logic       r_in_valid;
    t_in        r_in;
    logic       step;
    t_lex_out   lex_res;
    logic [1:0] q_free;
    logic [1:0] push_num;
    t_tok       q_tok;

    // Consume the held beat once the queue has room for all its tokens
    assign step            = r_in_valid && (lex_res.num <= q_free);
    assign o_s_axis_tready = !r_in_valid || step;
    assign push_num        = step ? lex_res.num : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in <= '{ch: i_s_axis_tdata, eos: i_s_axis_tlast};
        end
    end

    exprtok_lex #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
    ) u_lex (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_in    (r_in),
        .o_res   (lex_res)
    );

    exprtok_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_num (push_num),
        .i_tok0     (lex_res.tok0),
        .i_tok1     (lex_res.tok1),
        .o_free     (q_free),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_tok      (q_tok)
    );

    assign o_m_axis_tdata = {q_tok.len, q_tok.punct};
    assign o_m_axis_tuser = q_tok.kind;
    assign o_m_axis_tlast = q_tok.last;

endmodule

/* verif/tb_expression_tokenizer_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for expression_tokenizer_top: a directed table, then random streams with
// bursty input and a stalling output, each token checked against its row or a local scanner.
// Depends on exprtok_pkg and the tokenizer RTL.
module tb_expression_tokenizer_top;
    import exprtok_pkg::*;

    localparam int unsigned LEN_CAP         = (EXPRTOK_MAX_LEN > 255) ? 255 : EXPRTOK_MAX_LEN;
    localparam int unsigned RAND_ITEMS      = 750;
    localparam int unsigned WATCHDOG_CYCLES = 1000;
    localparam int unsigned TAIL_CYCLES     = 8;
    localparam int unsigned MAX_REPORTS     = 10;

    typedef enum int {RX_OPEN, RX_COIN, RX_COMB, RX_CHOKE} t_rx_mode;

    // One input beat; nfix >= 0 means the expected tokens are typed in the row itself
    typedef struct {
        logic [7:0] ch;
        logic       eos;
        int         nfix;
        t_tok       fix0;
        t_tok       fix1;
    } t_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = 8'h00;   // [7:0] ch
    logic        i_s_axis_tlast = 1'b0;    // end_of_stream
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;           // [7:0] punct_char, [15:8] token_length
    logic [3:0]  o_m_axis_tuser;           // [3:0] token_kind
    logic        o_m_axis_tlast;           // last

    expression_tokenizer_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_beat       feed_q[$];
    t_tok        pending_tokens[$];
    t_tok        step_toks[$];
    int unsigned bad_count = 0;
    int unsigned skip_count = 0;
    int unsigned quiet_cycles = 0;
    int unsigned rx_cyc = 0;
    t_rx_mode    rx_mode = RX_OPEN;

    string      op_chars = "=+-*/%^(),";
    logic [7:0] space_chars [6] = '{8'd32, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13};
    string      word_list [18] = '{"sin", "cos", "sqrt", "int", "L", "BA", "si", "sq", "sqr",
                                   "co", "in", "B", "Ba", "sinx", "cosh", "Lx", "ints", "sqrtt"};

    // Scanner state of the local tokeniser
    t_scan       lx_state = S_IDLE;
    logic [7:0]  lx_len = 8'd0;
    logic [31:0] lx_text = 32'd0;   // first four characters of a word, first one lowest
    bit          lx_halt = 1'b0;

    function automatic bit ch_space(input logic [7:0] c);
        foreach (space_chars[i]) if (c == space_chars[i]) return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit ch_alpha(input logic [7:0] c);
        logic [7:0] f;
        f = c | 8'h20;
        return (f >= "a") && (f <= "z") && (((c >= "A") && (c <= "Z")) || (c == f));
    endfunction

    function automatic bit ch_num(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic bit ch_op(input logic [7:0] c);
        for (int i = 0; i < op_chars.len(); i++) if (c == op_chars[i]) return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [7:0] bump(input logic [7:0] n);
        return (n >= LEN_CAP) ? n : n + 8'd1;
    endfunction

    function automatic t_tok mk_tok(input t_kind k, input logic [7:0] p, input logic [7:0] l,
                                    input logic last);
        t_tok t;
        t.kind  = k;
        t.punct = p;
        t.len   = l;
        t.last  = last;
        return t;
    endfunction

    function automatic void add_tok(input t_kind k, input logic [7:0] p, input logic [7:0] l);
        step_toks.push_back(mk_tok(k, p, l, 1'b0));
    endfunction

    function automatic void clear_tok();
        lx_state = S_IDLE;
        lx_len   = 8'd0;
        lx_text  = 32'd0;
    endfunction

    function automatic void grow(input t_scan s, input logic [7:0] c);
        if (s == S_IDENT && lx_len < 4) lx_text[8*lx_len +: 8] = c;
        lx_state = s;
        lx_len   = bump(lx_len);
    endfunction

    function automatic void halt_err(input logic [7:0] p, input logic [7:0] l);
        add_tok(K_ERROR, p, l);
        clear_tok();
        lx_halt = 1'b1;
    endfunction

    function automatic bit word_is(input string w);
        if (w.len() != lx_len) return 1'b0;
        for (int i = 0; i < w.len(); i++) if (w[i] != lx_text[8*i +: 8]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic t_kind word_kind();
        if (word_is("sin")) return K_SIN;
        if (word_is("cos")) return K_COS;
        if (word_is("sqrt")) return K_SQRT;
        if (word_is("int")) return K_INT;
        if (word_is("L")) return K_L;
        if (word_is("BA")) return K_BA;
        return K_IDENT;
    endfunction

    // Close a pending word or number
    function automatic void flush_word();
        if (lx_state == S_IDENT) add_tok(word_kind(), 8'd0, lx_len);
        else add_tok(K_NUMBER, 8'd0, lx_len);
        clear_tok();
    endfunction

    function automatic void scan_fresh(input logic [7:0] c);
        if (ch_space(c)) return;
        if (ch_alpha(c)) grow(S_IDENT, c);
        else if (ch_num(c)) grow(S_INT, c);
        else if (c == ".") grow(S_LEAD_DOT, c);
        else if (ch_op(c)) add_tok(K_PUNCT, c, 8'd1);
        else halt_err(c, 8'd1);
    endfunction

    // Tokens completed by one accepted beat, left in step_toks
    function automatic void tokenise_beat(input logic [7:0] c, input logic eos);
        step_toks.delete();
        if (eos) begin
            if (!lx_halt) begin
                case (lx_state)
                    S_IDENT, S_INT, S_FRAC, S_EXP_DIG: flush_word();
                    S_LEAD_DOT, S_EXP_START, S_EXP_SIGN: add_tok(K_ERROR, 8'd0, lx_len);
                    default: ;
                endcase
            end
            add_tok(K_EOF, 8'd0, 8'd0);
            clear_tok();
            lx_halt = 1'b0;
        end else if (!lx_halt) begin
            case (lx_state)
                S_IDENT: begin
                    if (ch_alpha(c)) grow(S_IDENT, c);
                    else begin
                        flush_word();
                        scan_fresh(c);
                    end
                end
                S_INT, S_FRAC: begin
                    if (ch_num(c)) grow(lx_state, c);
                    else if (c == "." && lx_state == S_INT) grow(S_FRAC, c);
                    else if (c == "e" || c == "E") grow(S_EXP_START, c);
                    else begin
                        flush_word();
                        scan_fresh(c);
                    end
                end
                S_LEAD_DOT: begin
                    if (ch_num(c)) grow(S_FRAC, c);
                    else halt_err(c, bump(lx_len));
                end
                S_EXP_START: begin
                    if (c == "+" || c == "-") grow(S_EXP_SIGN, c);
                    else if (ch_num(c)) grow(S_EXP_DIG, c);
                    else halt_err(c, bump(lx_len));
                end
                S_EXP_SIGN: begin
                    if (ch_num(c)) grow(S_EXP_DIG, c);
                    else halt_err(c, bump(lx_len));
                end
                S_EXP_DIG: begin
                    if (ch_num(c)) grow(S_EXP_DIG, c);
                    else begin
                        flush_word();
                        scan_fresh(c);
                    end
                end
                default: scan_fresh(c);
            endcase
        end
        if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
    endfunction

    function automatic void dir_row(input logic [7:0] c, input logic eos, input int nfix = -1,
                                    input t_tok f0 = '0, input t_tok f1 = '0);
        feed_q.push_back('{ch: c, eos: eos, nfix: nfix, fix0: f0, fix1: f1});
    endfunction

    function automatic void put_ch(input logic [7:0] c);
        dir_row(c, 1'b0);
    endfunction

    function automatic void put_digits(input int n);
        repeat (n) put_ch(8'("0" + $urandom_range(0, 9)));
    endfunction

    function automatic void put_space();
        put_ch(space_chars[$urandom_range(0, 5)]);
    endfunction

    function automatic logic [7:0] rand_letter();
        return $urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25))
                                    : 8'("A" + $urandom_range(0, 25));
    endfunction

    // Bytes after an error are ignored and do not count as stimulus
    function automatic void put_junk();
        int n;
        n = $urandom_range(0, 3);
        repeat (n) put_ch(8'($urandom_range(0, 255)));
        skip_count += n;
    endfunction

    // Output side: stall pattern, token check and watchdog
    always @(posedge i_clk) begin : token_check
        t_tok got;
        t_tok want;
        rx_cyc++;
        if (rx_cyc % 256 == 0) rx_mode = t_rx_mode'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:  i_m_axis_tready <= 1'b1;
            RX_COIN:  i_m_axis_tready <= 1'($urandom_range(0, 1));
            RX_COMB:  i_m_axis_tready <= (rx_cyc % 7) >= 3;
            default:  i_m_axis_tready <= (rx_cyc % 32) < 4;
        endcase
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.kind  = t_kind'(o_m_axis_tuser);
            got.punct = o_m_axis_tdata[7:0];
            got.len   = o_m_axis_tdata[15:8];
            got.last  = o_m_axis_tlast;
            if (pending_tokens.size() == 0) begin
                bad_count++;
                if (bad_count <= MAX_REPORTS)
                    $display("unexpected token: kind %0d punct %02h len %0d last %0d",
                             got.kind, got.punct, got.len, got.last);
            end else begin
                want = pending_tokens.pop_front();
                if (got.kind !== want.kind || got.punct !== want.punct ||
                    got.len !== want.len || got.last !== want.last) begin
                    bad_count++;
                    if (bad_count <= MAX_REPORTS) begin
                        $write("token mismatch: expected kind %0d punct %02h len %0d last %0d",
                               want.kind, want.punct, want.len, want.last);
                        $display(", got kind %0d punct %02h len %0d last %0d",
                                 got.kind, got.punct, got.len, got.last);
                    end
                end
            end
        end
        if (i_rst_n && ((i_s_axis_tvalid && o_s_axis_tready) ||
                        (o_m_axis_tvalid && i_m_axis_tready)))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("watchdog: no beat moved for %0d cycles", quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        t_beat       b;
        int unsigned dir_n;
        int unsigned mid;
        int unsigned burst_left;
        int unsigned gap;
        int          r;
        int          t;
        int          ntok;
        bit          broken;
        string       w;
        logic [7:0]  c;

        // Directed table
        dir_row(8'h00, 1'b1, 1, mk_tok(K_EOF, 8'h00, 8'd0, 1'b1));
        dir_row(8'hFF, 1'b0, 1, mk_tok(K_ERROR, 8'hFF, 8'd1, 1'b1));
        dir_row("a", 1'b0, 0);                       // halted: dropped
        dir_row(8'hFF, 1'b1, 1, mk_tok(K_EOF, 8'h00, 8'd0, 1'b1));
        dir_row("s", 1'b0);
        dir_row("q", 1'b0);
        dir_row("r", 1'b0);
        dir_row("t", 1'b0);
        dir_row("(", 1'b0);
        dir_row(".", 1'b0);
        dir_row("5", 1'b0);
        dir_row("E", 1'b0);
        dir_row("-", 1'b0);
        dir_row("9", 1'b0);
        dir_row("^", 1'b0);
        dir_row("B", 1'b0);
        dir_row("A", 1'b0);
        dir_row(8'd9, 1'b0);
        dir_row("1", 1'b0);
        dir_row("e", 1'b0);
        dir_row("x", 1'b0, 1, mk_tok(K_ERROR, "x", 8'd3, 1'b1));
        dir_row(8'h00, 1'b1, 1, mk_tok(K_EOF, 8'h00, 8'd0, 1'b1));
        dir_row("L", 1'b0);
        dir_row(8'h7F, 1'b1, 2, mk_tok(K_L, 8'h00, 8'd1, 1'b0),
                mk_tok(K_EOF, 8'h00, 8'd0, 1'b1));
        dir_row(".", 1'b0);
        dir_row(8'h80, 1'b1, 2, mk_tok(K_ERROR, 8'h00, 8'd1, 1'b0),
                mk_tok(K_EOF, 8'h00, 8'd0, 1'b1));
        dir_n = feed_q.size();

        // Saturating lengths: an over-long word and an over-long number
        repeat ($urandom_range(256, 260)) put_ch(rand_letter());
        put_space();
        put_digits($urandom_range(255, 258));
        put_ch("E");
        put_digits(2);
        dir_row(8'h00, 1'b1);

        // Random expression streams with some noise and broken numbers
        while (feed_q.size() - skip_count < dir_n + RAND_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                dir_row(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end else begin
                ntok = $urandom_range(1, 10);
                broken = 1'b0;
                for (int k = 0; k < ntok && !broken; k++) begin
                    t = $urandom_range(0, 99);
                    if (t < 20) begin
                        w = word_list[$urandom_range(0, $size(word_list) - 1)];
                        for (int i = 0; i < w.len(); i++) put_ch(w[i]);
                    end else if (t < 35) begin
                        repeat ($urandom_range(1, 6)) put_ch(rand_letter());
                    end else if (t < 60) begin
                        if ($urandom_range(0, 3) == 0) begin
                            put_ch(".");
                            put_digits($urandom_range(1, 3));
                        end else begin
                            put_digits($urandom_range(1, 4));
                            if ($urandom_range(0, 2) == 0) begin
                                put_ch(".");
                                put_digits($urandom_range(0, 3));
                            end
                        end
                        if ($urandom_range(0, 2) == 0) begin
                            put_ch($urandom_range(0, 1) ? "e" : "E");
                            case ($urandom_range(0, 2))
                                0: put_ch("+");
                                1: put_ch("-");
                                default: ;
                            endcase
                            put_digits($urandom_range(1, 2));
                        end
                    end else if (t < 85) begin
                        put_ch(op_chars[$urandom_range(0, op_chars.len() - 1)]);
                    end else if (t < 90) begin
                        repeat ($urandom_range(1, 3)) put_space();
                    end else if (t < 95) begin
                        // number cut short by a byte that cannot follow
                        case ($urandom_range(0, 2))
                            0: put_ch(".");
                            1: begin
                                put_digits($urandom_range(1, 3));
                                put_ch($urandom_range(0, 1) ? "e" : "E");
                            end
                            default: begin
                                put_digits($urandom_range(1, 3));
                                put_ch("e");
                                put_ch($urandom_range(0, 1) ? "+" : "-");
                            end
                        endcase
                        do c = 8'($urandom_range(0, 255));
                        while (ch_num(c) || c == "+" || c == "-");
                        put_ch(c);
                        put_junk();
                        broken = 1'b1;
                    end else begin
                        do c = 8'($urandom_range(0, 255));
                        while (ch_space(c) || ch_alpha(c) || ch_num(c) || c == "." || ch_op(c));
                        put_ch(c);
                        put_junk();
                        broken = 1'b1;
                    end
                    if (!broken && $urandom_range(0, 2) == 0) put_space();
                end
                // leave a number waiting for a digit at end of stream
                if (!broken && $urandom_range(0, 7) == 0) begin
                    if ($urandom_range(0, 1)) put_ch(".");
                    else begin
                        put_digits(1);
                        put_ch("e");
                    end
                end
                dir_row(8'($urandom_range(0, 255)), 1'b1);
                if ($urandom_range(0, 9) == 0) dir_row(8'($urandom_range(0, 255)), 1'b1);
            end
        end
        mid = dir_n + (feed_q.size() - dir_n) / 2;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        burst_left = 0;
        for (int idx = 0; idx < feed_q.size(); idx++) begin
            if (idx == dir_n || idx == mid) begin
                // hold off until every token seen so far has been read
                i_s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
                while (pending_tokens.size() != 0) @(posedge i_clk);
            end
            if (burst_left == 0) begin
                r = $urandom_range(0, 9);
                gap = (r < 3) ? 0 : ((r < 9) ? $urandom_range(1, 5) : $urandom_range(8, 20));
                if (gap != 0) begin
                    i_s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                         : $urandom_range(1, 24);
            end
            burst_left--;
            b = feed_q[idx];
            i_s_axis_tvalid <= 1'b1;
            i_s_axis_tdata  <= b.ch;
            i_s_axis_tlast  <= b.eos;
            @(posedge i_clk);
            while (!o_s_axis_tready) @(posedge i_clk);
            tokenise_beat(b.ch, b.eos);
            if (b.nfix < 0) begin
                foreach (step_toks[j]) pending_tokens.push_back(step_toks[j]);
            end else begin
                if (b.nfix > 0) pending_tokens.push_back(b.fix0);
                if (b.nfix > 1) pending_tokens.push_back(b.fix1);
            end
        end
        i_s_axis_tvalid <= 1'b0;

        while (pending_tokens.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (bad_count == 0 && pending_tokens.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* sim.f */
design/exprtok_pkg.sv
design/exprtok_lex.sv
design/exprtok_outq.sv
design/expression_tokenizer_top.sv
verif/tb_expression_tokenizer_top.sv
